// ----- rtl/lpr_pkg.sv -----
// Shared types and constants for the line pixel rasterizer.
package lpr_pkg;

  // Endpoint coordinates arrive with one spare bit so off-grid values can be seen.
  localparam int COORD_IN_W = 7;
  // Pixel coordinates on the grid.
  localparam int PIX_W = 6;

  // Largest legal column and row of the grid.
  localparam int GRID_MAX_COL = 63;
  localparam int GRID_MAX_ROW = 63;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } lpr_state_t;

endpackage

// ----- rtl/lpr_in_if.sv -----
// Input channel: one beat carries the two endpoints of a line.
interface lpr_in_if;
  logic                           valid;
  logic                           ready;
  logic [lpr_pkg::COORD_IN_W-1:0] start_x;
  logic [lpr_pkg::COORD_IN_W-1:0] start_y;
  logic [lpr_pkg::COORD_IN_W-1:0] end_x;
  logic [lpr_pkg::COORD_IN_W-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x, output end_y,
                  input ready);
  modport sink (input valid, input start_x, input start_y, input end_x, input end_y,
                output ready);
endinterface

// ----- rtl/lpr_out_if.sv -----
// Output channel: one beat carries one pixel of a line, or a rejection.
interface lpr_out_if;
  logic                      valid;
  logic                      ready;
  logic [lpr_pkg::PIX_W-1:0] pixel_x;
  logic [lpr_pkg::PIX_W-1:0] pixel_y;
  logic                      rejected;
  logic                      last;

  modport source (output valid, output pixel_x, output pixel_y, output rejected, output last,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input rejected, input last,
                output ready);
endinterface

// ----- rtl/line_pixel_rasterizer_unit.sv -----
// Line pixel rasterizer: walks the grid pixels between two endpoints.
//
// The block takes one line (two endpoints) per input beat and emits one output beat per
// pixel, in rising order of the major axis, with last set on the final pixel. A line whose
// endpoint lies off the grid (64 by 64 by default) yields a single beat with rejected and
// last set.
// The minor coordinate is the exact line value rounded half up, tracked as an integer
// quotient and remainder by one shared add/compare unit, one pixel per cycle while the
// output is not stalled. After a line is accepted, its endpoints are captured, the walk
// is set up and then its D + 1 pixels are loaded, D being the major span; only then can
// the next line be accepted. A rejected line loads its single beat. Output stalls hold
// the walk. Input ready is high only while the sequencer is idle; the output register
// lets the final pixel wait while the next line is taken.
module line_pixel_rasterizer_unit #(
  parameter int GRID_MAX_COL = lpr_pkg::GRID_MAX_COL,
  parameter int GRID_MAX_ROW = lpr_pkg::GRID_MAX_ROW
) (
  input logic        clk,
  input logic        rst,
  lpr_in_if.sink     line_in,
  lpr_out_if.source  pixel_out
);
  import lpr_pkg::*;

  // Sequencer and captured endpoints.
  lpr_state_t              state;
  logic [COORD_IN_W-1:0]   in_sx;
  logic [COORD_IN_W-1:0]   in_sy;
  logic [COORD_IN_W-1:0]   in_ex;
  logic [COORD_IN_W-1:0]   in_ey;

  // Walk state.
  logic                    rej;
  logic                    steep;
  logic [PIX_W-1:0]        step_index;
  logic [PIX_W-1:0]        step_end;
  logic [PIX_W-1:0]        base_major;
  logic [PIX_W-1:0]        minor;
  logic signed [PIX_W:0]   delta_minor;
  logic [PIX_W:0]          remainder;
  logic [PIX_W:0]          two_d;

  // Output register.
  logic                    out_valid;
  logic [PIX_W-1:0]        out_x;
  logic [PIX_W-1:0]        out_y;
  logic                    out_rej;
  logic                    out_last;

  // Setup values.
  logic signed [COORD_IN_W:0] dx;
  logic signed [COORD_IN_W:0] dy;
  logic signed [COORD_IN_W:0] adx;
  logic signed [COORD_IN_W:0] ady;
  logic                       in_range;
  logic                       shallow;
  logic [PIX_W-1:0]           s_major;
  logic [PIX_W-1:0]           s_minor;
  logic signed [COORD_IN_W:0] s_dm;
  logic [PIX_W-1:0]           s_d;
  logic [PIX_W-1:0]           s_div;

  // Step values.
  logic signed [PIX_W+2:0] acc_sum;
  logic signed [PIX_W+2:0] two_d_ext;
  logic [PIX_W:0]          remainder_next;
  logic [PIX_W-1:0]        minor_next;
  logic [PIX_W-1:0]        cur_major;
  logic                    is_last;
  logic                    load_out;

  // Spans and orientation of the captured line.
  always_comb begin
    dx  = signed'({1'b0, in_ex}) - signed'({1'b0, in_sx});
    dy  = signed'({1'b0, in_ey}) - signed'({1'b0, in_sy});
    adx = dx[COORD_IN_W] ? -dx : dx;
    ady = dy[COORD_IN_W] ? -dy : dy;
    in_range = (in_sx <= COORD_IN_W'(GRID_MAX_COL)) && (in_ex <= COORD_IN_W'(GRID_MAX_COL)) &&
               (in_sy <= COORD_IN_W'(GRID_MAX_ROW)) && (in_ey <= COORD_IN_W'(GRID_MAX_ROW));
    shallow = (dx != '0) && ((dy == '0) || (ady < adx));
    if (shallow) begin
      if (!dx[COORD_IN_W]) begin
        s_major = in_sx[PIX_W-1:0];
        s_minor = in_sy[PIX_W-1:0];
        s_dm    = dy;
      end else begin
        s_major = in_ex[PIX_W-1:0];
        s_minor = in_ey[PIX_W-1:0];
        s_dm    = -dy;
      end
      s_d = adx[PIX_W-1:0];
    end else begin
      if (!dy[COORD_IN_W]) begin
        s_major = in_sy[PIX_W-1:0];
        s_minor = in_sx[PIX_W-1:0];
        s_dm    = dx;
      end else begin
        s_major = in_ey[PIX_W-1:0];
        s_minor = in_ex[PIX_W-1:0];
        s_dm    = -dx;
      end
      s_d = ady[PIX_W-1:0];
    end
    // A zero span divides by one.
    s_div = (s_d == '0) ? PIX_W'(1) : s_d;
  end

  // Shared add/compare unit: advance the remainder by twice the minor span and fold it
  // back into [0, 2D) with one correction of the quotient.
  always_comb begin
    two_d_ext = signed'({2'b00, two_d});
    acc_sum   = signed'({2'b00, remainder}) +
                signed'({delta_minor[PIX_W], delta_minor, 1'b0});
    if (acc_sum >= two_d_ext) begin
      remainder_next = (PIX_W+1)'(acc_sum - two_d_ext);
      minor_next     = minor + PIX_W'(1);
    end else if (acc_sum[PIX_W+2]) begin
      remainder_next = (PIX_W+1)'(acc_sum + two_d_ext);
      minor_next     = minor - PIX_W'(1);
    end else begin
      remainder_next = acc_sum[PIX_W:0];
      minor_next     = minor;
    end
  end

  // Current pixel and output register load.
  assign cur_major = base_major + step_index;
  assign is_last   = rej || (step_index == step_end);
  assign load_out  = (state == ST_RUN) && (!out_valid || pixel_out.ready);

  // Sequencer, walk state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The output beat is set on a load and cleared once it is taken.
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pixel_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (line_in.valid) begin
            in_sx <= line_in.start_x;
            in_sy <= line_in.start_y;
            in_ex <= line_in.end_x;
            in_ey <= line_in.end_y;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          rej         <= !in_range;
          steep       <= !shallow;
          step_index  <= '0;
          step_end    <= s_d;
          base_major  <= s_major;
          minor       <= s_minor;
          delta_minor <= s_dm[PIX_W:0];
          remainder   <= {1'b0, s_div};
          two_d       <= {s_div, 1'b0};
          state       <= ST_RUN;
        end
        ST_RUN: begin
          if (load_out) begin
            out_rej   <= rej;
            out_last  <= is_last;
            if (rej) begin
              out_x <= '0;
              out_y <= '0;
            end else if (steep) begin
              out_x <= minor;
              out_y <= cur_major;
            end else begin
              out_x <= cur_major;
              out_y <= minor;
            end
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              step_index <= step_index + PIX_W'(1);
              remainder  <= remainder_next;
              minor      <= minor_next;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Port drive.
  assign line_in.ready      = (state == ST_IDLE);
  assign pixel_out.valid    = out_valid;
  assign pixel_out.pixel_x  = out_x;
  assign pixel_out.pixel_y  = out_y;
  assign pixel_out.rejected = out_rej;
  assign pixel_out.last     = out_last;

endmodule

// ----- tb/sv/tb_line_pixel_rasterizer_unit.sv -----
// Self-checking testbench for the line pixel rasterizer: directed lines, then random lines.
`timescale 1ns / 100ps

module tb_line_pixel_rasterizer_unit;
  import lpr_pkg::*;

  typedef logic [COORD_IN_W-1:0] coord_t;

  // One expected output beat.
  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             rejected;
    logic             last;
  } pixel_t;

  // One line to draw; known rows carry their single expected beat typed in.
  typedef struct packed {
    coord_t           sx;
    coord_t           sy;
    coord_t           ex;
    coord_t           ey;
    logic             known;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             rejected;
  } line_case_t;

  localparam int RANDOM_LINES   = 460;
  localparam int QUIET_LIMIT    = 1000;
  localparam int DIRECTED_COUNT = 22;

  // Endpoints, then the expected beat for rows that have one pixel or a rejection.
  localparam line_case_t DIRECTED_LINES [DIRECTED_COUNT] = '{
    '{0, 0, 0, 0, 1, 0, 0, 0},           // single point at the origin
    '{63, 63, 63, 63, 1, 63, 63, 0},     // single point at the far corner
    '{64, 0, 0, 0, 1, 0, 0, 1},          // start column just off the grid
    '{0, 127, 0, 0, 1, 0, 0, 1},         // start row at its largest code
    '{0, 0, 127, 0, 1, 0, 0, 1},         // end column at its largest code
    '{0, 0, 0, 64, 1, 0, 0, 1},          // end row just off the grid
    '{127, 127, 127, 127, 1, 0, 0, 1},   // everything off the grid
    '{85, 42, 21, 106, 1, 0, 0, 1},      // alternating bit patterns, off the grid
    '{42, 21, 42, 21, 1, 42, 21, 0},     // single point inside the grid
    '{0, 0, 63, 0, 0, 0, 0, 0},          // full-width horizontal
    '{63, 63, 0, 63, 0, 0, 0, 0},        // horizontal given right to left
    '{0, 63, 0, 0, 0, 0, 0, 0},          // full-height vertical given top down
    '{0, 0, 63, 63, 0, 0, 0, 0},         // main diagonal
    '{63, 0, 0, 63, 0, 0, 0, 0},         // anti-diagonal
    '{0, 0, 2, 1, 0, 0, 0, 0},           // shallow line with a halfway tie
    '{2, 1, 0, 0, 0, 0, 0, 0},           // the same line with endpoints swapped
    '{0, 0, 1, 2, 0, 0, 0, 0},           // steep line with a halfway tie
    '{0, 5, 4, 2, 0, 0, 0, 0},           // shallow line falling
    '{10, 20, 7, 40, 0, 0, 0, 0},        // steep line leaning back
    '{63, 62, 0, 0, 0, 0, 0, 0},         // shallow, just under a diagonal
    '{1, 0, 0, 63, 0, 0, 0, 0},          // steep, nearly vertical
    '{63, 0, 62, 0, 0, 0, 0, 0}          // two-pixel horizontal
  };

  logic clk = 1'b0;
  logic rst;

  lpr_in_if  line_if ();
  lpr_out_if pix_if ();

  line_pixel_rasterizer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .line_in   (line_if),
    .pixel_out (pix_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_t pending_pixels [$];
  int     mismatch_count = 0;
  int     quiet_cycles   = 0;
  int     stall_left     = 0;
  bit     idle_on        = 1'b1;

  // Expected pixels of one line, in rising order of the major axis.
  function automatic void rasterize_line(input coord_t sx, input coord_t sy,
                                         input coord_t ex, input coord_t ey);
    int     dx;
    int     dy;
    int     adx;
    int     ady;
    int     major_base;
    int     minor_base;
    int     minor_span;
    int     span;
    int     divisor;
    int     num;
    int     minor;
    bit     steep;
    pixel_t p;
    if (sx > GRID_MAX_COL || ex > GRID_MAX_COL || sy > GRID_MAX_ROW || ey > GRID_MAX_ROW) begin
      p = '{x: '0, y: '0, rejected: 1'b1, last: 1'b1};
      pending_pixels.push_back(p);
      return;
    end
    dx  = int'(ex) - int'(sx);
    dy  = int'(ey) - int'(sy);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    steep = !(dx != 0 && (dy == 0 || ady < adx));
    // Start from the endpoint with the smaller major coordinate.
    if (!steep) begin
      span = adx;
      if (dx > 0) begin
        major_base = int'(sx); minor_base = int'(sy); minor_span = dy;
      end else begin
        major_base = int'(ex); minor_base = int'(ey); minor_span = -dy;
      end
    end else begin
      span = ady;
      if (dy >= 0) begin
        major_base = int'(sy); minor_base = int'(sx); minor_span = dx;
      end else begin
        major_base = int'(ey); minor_base = int'(ex); minor_span = -dx;
      end
    end
    divisor = (span == 0) ? 1 : span;
    // Minor coordinate is floor(base + i * slope + 1/2), kept exact with integers.
    for (int i = 0; i <= span; i++) begin
      num   = (2 * minor_base + 1) * divisor + 2 * i * minor_span;
      minor = num / (2 * divisor);
      p.x        = steep ? PIX_W'(minor) : PIX_W'(major_base + i);
      p.y        = steep ? PIX_W'(major_base + i) : PIX_W'(minor);
      p.rejected = 1'b0;
      p.last     = (i == span);
      pending_pixels.push_back(p);
    end
  endfunction

  // Random line: mostly in-grid lines of mixed shapes, some off-grid endpoints.
  function automatic line_case_t random_line();
    line_case_t c;
    int         roll;
    int         len;
    int         lo;
    c = '0;
    roll = $urandom_range(0, 19);
    if (roll < 2) begin
      c.sx = coord_t'($urandom_range(0, 127));
      c.sy = coord_t'($urandom_range(0, 127));
      c.ex = coord_t'($urandom_range(0, 127));
      c.ey = coord_t'($urandom_range(0, 127));
      case ($urandom_range(0, 3))
        0: c.sx = coord_t'($urandom_range(64, 127));
        1: c.sy = coord_t'($urandom_range(64, 127));
        2: c.ex = coord_t'($urandom_range(64, 127));
        default: c.ey = coord_t'($urandom_range(64, 127));
      endcase
    end else if (roll == 2) begin
      c.sx = coord_t'($urandom_range(0, 63));
      c.ex = coord_t'($urandom_range(0, 63));
      c.sy = coord_t'($urandom_range(0, 63));
      c.ey = c.sy;
    end else if (roll == 3) begin
      c.sx = coord_t'($urandom_range(0, 63));
      c.ex = c.sx;
      c.sy = coord_t'($urandom_range(0, 63));
      c.ey = coord_t'($urandom_range(0, 63));
    end else if (roll == 4) begin
      // Diagonal: equal spans, either direction.
      c.sx = coord_t'($urandom_range(0, 63));
      c.ex = coord_t'($urandom_range(0, 63));
      len  = (c.sx > c.ex) ? int'(c.sx) - int'(c.ex) : int'(c.ex) - int'(c.sx);
      lo   = $urandom_range(0, 63 - len);
      if ($urandom_range(0, 1) == 1) begin
        c.sy = coord_t'(lo); c.ey = coord_t'(lo + len);
      end else begin
        c.sy = coord_t'(lo + len); c.ey = coord_t'(lo);
      end
    end else if (roll < 12) begin
      // Short line around a random start.
      c.sx = coord_t'($urandom_range(0, 63));
      c.sy = coord_t'($urandom_range(0, 63));
      lo   = int'(c.sx) + int'($urandom_range(0, 16)) - 8;
      c.ex = (lo < 0) ? coord_t'(0) : (lo > 63) ? coord_t'(63) : coord_t'(lo);
      lo   = int'(c.sy) + int'($urandom_range(0, 16)) - 8;
      c.ey = (lo < 0) ? coord_t'(0) : (lo > 63) ? coord_t'(63) : coord_t'(lo);
    end else begin
      c.sx = coord_t'($urandom_range(0, 63));
      c.sy = coord_t'($urandom_range(0, 63));
      c.ex = coord_t'($urandom_range(0, 63));
      c.ey = coord_t'($urandom_range(0, 63));
    end
    return c;
  endfunction

  // Line source: directed rows first, then random lines, with bursts of idle cycles.
  initial begin
    line_case_t row;
    pixel_t     typed_pixel;
    int         total;
    total = DIRECTED_COUNT + RANDOM_LINES;
    rst             <= 1'b1;
    line_if.valid   <= 1'b0;
    line_if.start_x <= '0;
    line_if.start_y <= '0;
    line_if.end_x   <= '0;
    line_if.end_y   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < total; k++) begin
      if (k < DIRECTED_COUNT) begin
        row = DIRECTED_LINES[k];
      end else begin
        row = random_line();
      end
      // Idling comes in stretches of 30 lines, with one quiet stretch in four and none at the end.
      idle_on = (k < total - 60) && (((k / 30) % 4) != 3);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        line_if.valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      line_if.valid   <= 1'b1;
      line_if.start_x <= row.sx;
      line_if.start_y <= row.sy;
      line_if.end_x   <= row.ex;
      line_if.end_y   <= row.ey;
      do @(posedge clk); while (!line_if.ready);
      if (row.known) begin
        typed_pixel = '{x: row.px, y: row.py, rejected: row.rejected, last: 1'b1};
        pending_pixels.push_back(typed_pixel);
      end else begin
        rasterize_line(row.sx, row.sy, row.ex, row.ey);
      end
    end
    line_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Pixel sink: compares each accepted beat with the oldest expected pixel.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pix_if.valid && pix_if.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual x=%0d y=%0d rejected=%0b last=%0b",
                 $time, pix_if.pixel_x, pix_if.pixel_y, pix_if.rejected, pix_if.last);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pix_if.pixel_x !== want.x) begin
          $display("%0t: pixel_x mismatch: expected %0d, actual %0d",
                   $time, want.x, pix_if.pixel_x);
          mismatch_count++;
        end
        if (pix_if.pixel_y !== want.y) begin
          $display("%0t: pixel_y mismatch: expected %0d, actual %0d",
                   $time, want.y, pix_if.pixel_y);
          mismatch_count++;
        end
        if (pix_if.rejected !== want.rejected) begin
          $display("%0t: rejected mismatch: expected %0b, actual %0b",
                   $time, want.rejected, pix_if.rejected);
          mismatch_count++;
        end
        if (pix_if.last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, want.last, pix_if.last);
          mismatch_count++;
        end
      end
    end
    // Back-pressure in random bursts while idling is on.
    if (rst) begin
      stall_left = 0;
      pix_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pix_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 17);
      pix_if.ready <= 1'b0;
    end else begin
      pix_if.ready <= 1'b1;
    end
  end

  // Watchdog: too many cycles without any beat on either side ends the run.
  always @(posedge clk) begin
    if (rst || (line_if.valid && line_if.ready) || (pix_if.valid && pix_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
